### rtl/irp_pkg.sv
// Shared constants, codes and types of the iteration rainbow palette.
`default_nettype none

package irp_pkg;

  // Width of an iteration count word.
  localparam int COUNT_BITS = 16;

  localparam int NCOL_W  = 16;          // palette length
  localparam int ITER_W  = 16;          // iteration limit
  localparam int INT_W   = 10;          // intensity, unsigned Q2.8
  localparam int CFG_W   = 16;          // widest register
  localparam int CFG_IDX_W = 2;
  localparam int CMP_W   = (COUNT_BITS > ITER_W) ? COUNT_BITS : ITER_W;

  localparam int M6_W    = NCOL_W + 3;  // holds 6 * m
  localparam int NUM_W   = NCOL_W + 9;  // channel numerator times intensity
  localparam int QBITS   = 8;           // quotient bits of the channel scale
  localparam int CHAN_W  = 8;
  localparam int COLOR_W = 3 * CHAN_W;
  localparam int SEC_W   = 3;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTENSITY   = 2'd2;

  // Register reset values.
  localparam logic [NCOL_W-1:0] PALETTE_LEN_RST = 16'd16;
  localparam logic [ITER_W-1:0] ITER_LIMIT_RST  = 16'd1000;
  localparam logic [INT_W-1:0]  INT_ONE         = 10'd256;
  localparam logic [INT_W-1:0]  INT_MAX         = 10'd512;

  // Rainbow sectors.
  localparam logic [SEC_W-1:0] SEC_RED     = 3'd0;
  localparam logic [SEC_W-1:0] SEC_YELLOW  = 3'd1;
  localparam logic [SEC_W-1:0] SEC_GREEN   = 3'd2;
  localparam logic [SEC_W-1:0] SEC_CYAN    = 3'd3;
  localparam logic [SEC_W-1:0] SEC_BLUE    = 3'd4;
  localparam logic [SEC_W-1:0] SEC_MAGENTA = 3'd5;

  // Control that travels with each word down the pipe.
  typedef struct packed {
    logic valid;
    logic black;
  } irp_ctl_t;

endpackage

`default_nettype wire

### rtl/irp_rem.sv
// Pipelined remainder unit: count modulo the palette length, one dividend bit per stage.
`default_nettype none

module irp_rem (
  input  logic                              clk,
  input  logic                              rst,
  input  irp_pkg::irp_ctl_t                 ctl_in,
  input  logic [irp_pkg::COUNT_BITS-1:0]    cnt_in,
  input  logic [irp_pkg::NCOL_W-1:0]        n,
  output irp_pkg::irp_ctl_t                 ctl_out,
  output logic [irp_pkg::NCOL_W-1:0]        rem_out
);
  import irp_pkg::*;

  wire [NCOL_W-1:0]     rem_w [0:COUNT_BITS];
  wire [COUNT_BITS-1:0] cnt_w [0:COUNT_BITS-1];
  wire irp_ctl_t        ctl_w [0:COUNT_BITS];

  assign rem_w[0] = '0;
  assign cnt_w[0] = cnt_in;
  assign ctl_w[0] = ctl_in;

  genvar k;
  for (k = 0; k < COUNT_BITS; k++) begin : g_step
    logic [NCOL_W:0]   trial;
    logic [NCOL_W-1:0] rem_q;
    irp_ctl_t          ctl_q;

    // Bring down the next dividend bit; remainder stays below n.
    assign trial = {rem_w[k], cnt_w[k][COUNT_BITS-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_q <= '0;
      end else begin
        ctl_q <= ctl_w[k];
      end
      if (trial >= {1'b0, n}) begin
        rem_q <= NCOL_W'(trial - {1'b0, n});
      end else begin
        rem_q <= trial[NCOL_W-1:0];
      end
    end

    assign rem_w[k+1] = rem_q;
    assign ctl_w[k+1] = ctl_q;

    if (k < COUNT_BITS - 1) begin : g_shift
      logic [COUNT_BITS-1:0] cnt_q;
      always_ff @(posedge clk) begin
        cnt_q <= {cnt_w[k][COUNT_BITS-2:0], 1'b0};
      end
      assign cnt_w[k+1] = cnt_q;
    end
  end

  assign rem_out = rem_w[COUNT_BITS];
  assign ctl_out = ctl_w[COUNT_BITS];

endmodule

`default_nettype wire

### rtl/irp_sector.sv
// Sector and ramp stages: position on the rainbow to per-channel numerators.
`default_nettype none

module irp_sector (
  input  logic                        clk,
  input  logic                        rst,
  input  irp_pkg::irp_ctl_t           ctl_in,
  input  logic [irp_pkg::NCOL_W-1:0]  m,
  input  logic [irp_pkg::NCOL_W-1:0]  n,
  output irp_pkg::irp_ctl_t           ctl_out,
  output logic [irp_pkg::NCOL_W-1:0]  chan_r,
  output logic [irp_pkg::NCOL_W-1:0]  chan_g,
  output logic [irp_pkg::NCOL_W-1:0]  chan_b
);
  import irp_pkg::*;

  // Multiples of n; that n moves only while idle is up to the user, with no check here.
  logic [M6_W-1:0] n1, n2, n3, n4, n5;

  logic [M6_W-1:0]   m6;
  irp_ctl_t          ctl1, ctl2, ctl3;
  logic [SEC_W-1:0]  sec_next, sec;
  logic [M6_W-1:0]   base_next;
  logic [NCOL_W-1:0] p;

  always_ff @(posedge clk) begin
    n1 <= M6_W'(n);
    n2 <= M6_W'({n, 1'b0});
    n3 <= M6_W'({n, 1'b0}) + M6_W'(n);
    n4 <= M6_W'({n, 2'b0});
    n5 <= M6_W'({n, 2'b0}) + M6_W'(n);
  end

  // Stage 1: 6m.
  always_ff @(posedge clk) begin
    m6 <= M6_W'({m, 2'b0}) + M6_W'({m, 1'b0});
  end

  // Stage 2: sector is floor(6m / n), ramp is what is left.
  always_comb begin
    if (m6 >= n5) begin
      sec_next  = SEC_MAGENTA;
      base_next = n5;
    end else if (m6 >= n4) begin
      sec_next  = SEC_BLUE;
      base_next = n4;
    end else if (m6 >= n3) begin
      sec_next  = SEC_CYAN;
      base_next = n3;
    end else if (m6 >= n2) begin
      sec_next  = SEC_GREEN;
      base_next = n2;
    end else if (m6 >= n1) begin
      sec_next  = SEC_YELLOW;
      base_next = n1;
    end else begin
      sec_next  = SEC_RED;
      base_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    sec <= sec_next;
    p   <= NCOL_W'(m6 - base_next);
  end

  // Stage 3: full, zero or ramp per channel.
  always_ff @(posedge clk) begin
    case (sec)
      SEC_RED: begin
        chan_r <= n;       chan_g <= p;       chan_b <= '0;
      end
      SEC_YELLOW: begin
        chan_r <= n - p;   chan_g <= n;       chan_b <= '0;
      end
      SEC_GREEN: begin
        chan_r <= '0;      chan_g <= n;       chan_b <= p;
      end
      SEC_CYAN: begin
        chan_r <= '0;      chan_g <= n - p;   chan_b <= n;
      end
      SEC_BLUE: begin
        chan_r <= p;       chan_g <= '0;      chan_b <= n;
      end
      SEC_MAGENTA: begin
        chan_r <= n;       chan_g <= '0;      chan_b <= n - p;
      end
      default: begin
        chan_r <= '0;      chan_g <= '0;      chan_b <= '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
      ctl2 <= '0;
      ctl3 <= '0;
    end else begin
      ctl1 <= ctl_in;
      ctl2 <= ctl1;
      ctl3 <= ctl2;
    end
  end

  assign ctl_out = ctl3;

endmodule

`default_nettype wire

### rtl/irp_shade.sv
// Intensity and 8-bit scaling of three channels: multiply, then a pipelined quotient.
`default_nettype none

module irp_shade (
  input  logic                         clk,
  input  logic                         rst,
  input  irp_pkg::irp_ctl_t            ctl_in,
  input  logic [irp_pkg::NCOL_W-1:0]   chan_r,
  input  logic [irp_pkg::NCOL_W-1:0]   chan_g,
  input  logic [irp_pkg::NCOL_W-1:0]   chan_b,
  input  logic [irp_pkg::NCOL_W-1:0]   n,
  input  logic [irp_pkg::INT_W-1:0]    i,
  output irp_pkg::irp_ctl_t            ctl_out,
  output logic [irp_pkg::COLOR_W-1:0]  color
);
  import irp_pkg::*;

  localparam int STAGES = QBITS + 2;

  wire [NCOL_W-1:0] a_w [0:2];
  wire [CHAN_W-1:0] quot_w [0:2];
  logic             hi;
  logic [INT_W-1:0] my;

  assign a_w[0] = chan_r;
  assign a_w[1] = chan_g;
  assign a_w[2] = chan_b;

  // Above one, blend toward white: a*256 + (n-a)*(i-256).
  assign hi = (i > INT_ONE);
  assign my = hi ? (i - INT_ONE) : i;

  genvar l, j;
  for (l = 0; l < 3; l++) begin : g_lane
    logic [NCOL_W-1:0]   mx;
    logic [NUM_W-1:0]    add;
    logic [NUM_W-1:0]    num;
    logic [NUM_W+7:0]    scaled;
    logic [NUM_W-1:0]    y;
    wire  [NUM_W-1:0]    res_w [0:QBITS];
    wire  [CHAN_W-1:0]   q_w [0:QBITS];

    assign mx  = hi ? (n - a_w[l]) : a_w[l];
    assign add = hi ? NUM_W'({a_w[l], 8'b0}) : '0;

    always_ff @(posedge clk) begin
      num <= NUM_W'(NUM_W'(mx) * NUM_W'(my)) + add;
    end

    // floor(255*num/256), then divide by n below.
    assign scaled = {num, 8'b0} - {8'b0, num};

    always_ff @(posedge clk) begin
      y <= scaled[NUM_W+7:8];
    end

    assign res_w[0] = y;
    assign q_w[0]   = '0;

    for (j = 0; j < QBITS; j++) begin : g_div
      logic [NUM_W-1:0]  d;
      logic [NUM_W-1:0]  res_q;
      logic [CHAN_W-1:0] q_q;

      assign d = NUM_W'(n) << (QBITS - 1 - j);

      always_ff @(posedge clk) begin
        if (res_w[j] >= d) begin
          res_q <= res_w[j] - d;
          q_q   <= q_w[j] | (CHAN_W'(1) << (QBITS - 1 - j));
        end else begin
          res_q <= res_w[j];
          q_q   <= q_w[j];
        end
      end

      assign res_w[j+1] = res_q;
      assign q_w[j+1]   = q_q;
    end

    assign quot_w[l] = q_w[QBITS];
  end

  wire irp_ctl_t ctl_w [0:STAGES];
  assign ctl_w[0] = ctl_in;

  for (j = 0; j < STAGES; j++) begin : g_ctl
    irp_ctl_t ctl_q;
    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_q <= '0;
      end else begin
        ctl_q <= ctl_w[j];
      end
    end
    assign ctl_w[j+1] = ctl_q;
  end

  assign ctl_out = ctl_w[STAGES];
  assign color   = {quot_w[2], quot_w[1], quot_w[0]};

endmodule

`default_nettype wire

### rtl/iteration_rainbow_palette.sv
// Top level of the iteration rainbow palette: registers, input and output stages.
`default_nettype none

// Colors one pixel's iteration count per clock. A word is taken at each edge
// where start is high and busy is low; busy is high only during reset, so a
// new count may follow every cycle. The packed color appears on pixel_color
// with done high for one cycle, in the order the words went in. On the way
// the word passes the remainder pipe, which retires one count bit per stage,
// and the eight-stage quotient that scales each channel to 8 bits. Results
// cannot be held off. Write registers only while no word is in flight.

module iteration_rainbow_palette (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [irp_pkg::COUNT_BITS-1:0]   iter_count,
  output logic                             busy,
  output logic                             done,
  output logic [irp_pkg::COLOR_W-1:0]      pixel_color,
  input  logic                             cfg_we,
  input  logic [irp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [irp_pkg::CFG_W-1:0]        cfg_data
);
  import irp_pkg::*;

  logic [NCOL_W-1:0]     palette_len;
  logic [ITER_W-1:0]     iter_limit;
  logic [INT_W-1:0]      intensity;
  logic [NCOL_W-1:0]     n_eff;
  logic [INT_W-1:0]      i_eff;

  irp_ctl_t              in_ctl;
  logic [COUNT_BITS-1:0] cnt;
  irp_ctl_t              rem_ctl, sec_ctl, shd_ctl;
  logic [NCOL_W-1:0]     m;
  logic [NCOL_W-1:0]     chan_r, chan_g, chan_b;
  logic [COLOR_W-1:0]    color;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_len <= PALETTE_LEN_RST;
      iter_limit  <= ITER_LIMIT_RST;
      intensity   <= INT_ONE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PALETTE_LEN: palette_len <= cfg_data[NCOL_W-1:0];
        REG_ITER_LIMIT:  iter_limit  <= cfg_data[ITER_W-1:0];
        REG_INTENSITY:   intensity   <= cfg_data[INT_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero colors acts as one; intensity saturates at white.
  always_ff @(posedge clk) begin
    n_eff <= (palette_len == '0) ? NCOL_W'(1) : palette_len;
    i_eff <= (intensity > INT_MAX) ? INT_MAX : intensity;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_ctl <= '0;
    end else begin
      in_ctl.valid <= start & ~busy;
      in_ctl.black <= CMP_W'(iter_count) >= CMP_W'(iter_limit);
    end
    cnt <= iter_count;
  end

  irp_rem u_rem (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (in_ctl),
    .cnt_in  (cnt),
    .n       (n_eff),
    .ctl_out (rem_ctl),
    .rem_out (m)
  );

  irp_sector u_sector (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (rem_ctl),
    .m       (m),
    .n       (n_eff),
    .ctl_out (sec_ctl),
    .chan_r  (chan_r),
    .chan_g  (chan_g),
    .chan_b  (chan_b)
  );

  irp_shade u_shade (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (sec_ctl),
    .chan_r  (chan_r),
    .chan_g  (chan_g),
    .chan_b  (chan_b),
    .n       (n_eff),
    .i       (i_eff),
    .ctl_out (shd_ctl),
    .color   (color)
  );

  // Output black for counts at or above the limit.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= shd_ctl.valid;
    end
    pixel_color <= shd_ctl.black ? '0 : color;
  end

endmodule

`default_nettype wire
